FILE: rtl/iapee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iapee_pkg;

    // Controller sequencing
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ERASE
    } state_t;

    // Bus access kind
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register map
    localparam logic [2:0] REG_DATA    = 3'd0;
    localparam logic [2:0] REG_ADDR_HI = 3'd1;
    localparam logic [2:0] REG_ADDR_LO = 3'd2;
    localparam logic [2:0] REG_COMMAND = 3'd3;
    localparam logic [2:0] REG_TRIGGER = 3'd4;
    localparam logic [2:0] REG_CONTROL = 3'd5;
    localparam logic [2:0] REG_TIMING  = 3'd6;

    // Store commands
    localparam logic [1:0] CMD_IDLE    = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_PROGRAM = 2'd2;
    localparam logic [1:0] CMD_ERASE   = 2'd3;

    // Trigger sequence and misc constants
    localparam logic [7:0] TRIG_FIRST  = 8'h5A;
    localparam logic [7:0] TRIG_SECOND = 8'hA5;
    localparam int         ENABLE_BIT  = 7;
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

endpackage

`default_nettype wire

FILE: rtl/iap_eeprom_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Result of every transaction is registered: it is offered in the cycle after acceptance.
// Throughput: one transaction per cycle for register accesses while the output is not stalled;
// a fired read command holds off the input for one memory read, a page erase until the whole page
// is written (one byte written per cycle through the single memory port).
// Reset (aresetn low, synchronous) clears the control registers but not the output data register,
// then sweeps the store to 0xFF, one byte per cycle: no input is accepted until the sweep ends.

module iap_eeprom_controller #(
    parameter int STORE_BYTES = 4096,  // power of two, 512 .. 32768
    parameter int PAGE_BYTES  = 512    // power of two, 64 .. 4096
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] write_data
    input  wire logic [3:0] s_tuser,   // [0] cmd, [3:1] reg_sel
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [7:0] read_data
);
    import iapee_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [AW-1:0] LAST_IDX  = AW'(STORE_BYTES - 1);
    localparam logic [AW-1:0] PAGE_MASK = AW'(PAGE_BYTES - 1);
    localparam logic [16:0]   STORE_LIM = 17'(STORE_BYTES);

    // Byte store
    logic [7:0] mem [STORE_BYTES];
    logic [7:0] mem_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;

    state_t state_reg, state_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [7:0]  data_reg, data_next;
    logic [15:0] addr_reg, addr_next;
    logic [1:0]  command_reg, command_next;
    logic [7:0]  control_reg, control_next;
    logic [7:0]  timing_reg, timing_next;
    logic        armed_reg, armed_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;

    logic          accept;
    logic          is_write;
    logic [2:0]    sel;
    logic [7:0]    wd;
    logic          in_range;
    logic          fire;
    logic [AW-1:0] addr_idx;
    logic          erase_done;
    logic [7:0]    rd_value;

    assign is_write = s_tuser[0];
    assign sel      = s_tuser[3:1];
    assign wd       = s_tdata;
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign addr_idx   = addr_reg[AW-1:0];
    assign in_range   = ({1'b0, addr_reg} < STORE_LIM);
    assign erase_done = ((ptr_reg & PAGE_MASK) == PAGE_MASK) || (ptr_reg == LAST_IDX);

    // Completed trigger sequence with enable set and a valid address
    assign fire = accept && (is_write == OP_WRITE) && (sel == REG_TRIGGER)
               && (wd == TRIG_SECOND) && armed_reg && control_reg[ENABLE_BIT] && in_range;

    // Register readback
    always_comb begin
        case (sel)
            REG_DATA:    rd_value = data_reg;
            REG_ADDR_HI: rd_value = addr_reg[15:8];
            REG_ADDR_LO: rd_value = addr_reg[7:0];
            REG_COMMAND: rd_value = {6'd0, command_reg};
            REG_CONTROL: rd_value = control_reg;
            REG_TIMING:  rd_value = timing_reg;
            default:     rd_value = 8'd0;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (ptr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (fire && command_reg == CMD_READ) begin
                    state_next = ST_READ;
                end else if (fire && command_reg == CMD_ERASE) begin
                    state_next = ST_ERASE;
                end
            end
            ST_READ: begin
                state_next = ST_IDLE;
            end
            ST_ERASE: begin
                if (erase_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        ptr_next       = ptr_reg;
        data_next      = data_reg;
        addr_next      = addr_reg;
        command_next   = command_reg;
        control_next   = control_reg;
        timing_next    = timing_reg;
        armed_next     = armed_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_addr       = addr_idx;
        mem_wdata      = data_reg;

        // Output register drains independently of the input side
        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = ptr_reg;
                mem_wdata = ERASED_BYTE;
                ptr_next  = ptr_reg + AW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    out_valid_next = 1'b1;
                    out_data_next  = (is_write == OP_WRITE) ? 8'd0 : rd_value;
                    if (is_write == OP_WRITE) begin
                        case (sel)
                            REG_DATA:    data_next = wd;
                            REG_ADDR_HI: addr_next = {wd, addr_reg[7:0]};
                            REG_ADDR_LO: addr_next = {addr_reg[15:8], wd};
                            REG_COMMAND: command_next = wd[1:0];
                            REG_TRIGGER: armed_next = (wd == TRIG_FIRST);
                            REG_CONTROL: control_next = wd;
                            REG_TIMING:  timing_next = wd;
                            default: ;
                        endcase
                    end
                end
                if (fire) begin
                    case (command_reg)
                        CMD_PROGRAM: mem_we = 1'b1;
                        CMD_ERASE:   ptr_next = addr_idx & ~PAGE_MASK;
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                data_next = mem_rdata_reg;
            end
            ST_ERASE: begin
                mem_we    = 1'b1;
                mem_addr  = ptr_reg;
                mem_wdata = ERASED_BYTE;
                ptr_next  = ptr_reg + AW'(1);
            end
            default: ;
        endcase
    end

    // Store memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    // Control and register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            data_reg      <= 8'd0;
            addr_reg      <= 16'd0;
            command_reg   <= CMD_IDLE;
            control_reg   <= 8'd0;
            timing_reg    <= 8'd0;
            armed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            data_reg      <= data_next;
            addr_reg      <= addr_next;
            command_reg   <= command_next;
            control_reg   <= control_next;
            timing_reg    <= timing_next;
            armed_reg     <= armed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import iapee_pkg::*;

    localparam int STORE_BYTES = 4096;
    localparam int PAGE_BYTES  = 512;
    localparam int RANDOM_ACCESSES = 1000;
    localparam int HOLD_CYCLES = 200;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // One expected read_data transaction, tagged with the access that caused it
    typedef struct packed {
        logic       acc;
        logic [2:0] sel;
        logic [7:0] read_data;
    } readback_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] write_data
    logic [3:0] s_tuser;   // [0] cmd, [3:1] reg_sel
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] read_data

    // Shadow of the register file and the byte store
    logic [7:0]  flash_img [STORE_BYTES];
    logic [7:0]  data_r;
    logic [15:0] addr_r;
    logic [1:0]  cmd_r;
    logic [7:0]  ctrl_r;
    logic [7:0]  timing_r;
    logic        armed_r;

    readback_t readback_q[$];
    readback_t want;
    int fail_count;
    int items_sent;
    int n_store_reads, n_programs, n_erases, n_ignored;
    bit idle_enable;
    bit hold_request;

    iap_eeprom_controller #(
        .STORE_BYTES(STORE_BYTES),
        .PAGE_BYTES (PAGE_BYTES)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Store command fired by a completed trigger sequence
    function automatic void run_store_command();
        int unsigned base;
        if (!ctrl_r[ENABLE_BIT] || addr_r >= STORE_BYTES) begin
            if (cmd_r != CMD_IDLE) n_ignored++;
            return;
        end
        case (cmd_r)
            CMD_READ: begin
                data_r = flash_img[addr_r];
                n_store_reads++;
            end
            CMD_PROGRAM: begin
                flash_img[addr_r] = data_r;
                n_programs++;
            end
            CMD_ERASE: begin
                base = addr_r - (addr_r % PAGE_BYTES);
                for (int i = 0; i < PAGE_BYTES && base + i < STORE_BYTES; i++)
                    flash_img[base + i] = ERASED_BYTE;
                n_erases++;
            end
            default: ;
        endcase
    endfunction

    // Unlock sequence: first key arms, second key fires, anything else disarms
    function automatic void trigger_write(logic [7:0] v);
        if (v == TRIG_FIRST) begin
            armed_r = 1'b1;
        end else if (v == TRIG_SECOND && armed_r) begin
            armed_r = 1'b0;
            run_store_command();
        end else begin
            armed_r = 1'b0;
        end
    endfunction

    // Applies one bus access to the shadow state, returns the byte read back
    function automatic logic [7:0] bus_access_readback(logic acc, logic [2:0] sel,
                                                       logic [7:0] wd);
        logic [7:0] rd;
        rd = 8'h00;
        if (acc == OP_WRITE) begin
            case (sel)
                REG_DATA:    data_r = wd;
                REG_ADDR_HI: addr_r[15:8] = wd;
                REG_ADDR_LO: addr_r[7:0] = wd;
                REG_COMMAND: cmd_r = wd[1:0];
                REG_TRIGGER: trigger_write(wd);
                REG_CONTROL: ctrl_r = wd;
                REG_TIMING:  timing_r = wd;
                default: ;
            endcase
        end else begin
            case (sel)
                REG_DATA:    rd = data_r;
                REG_ADDR_HI: rd = addr_r[15:8];
                REG_ADDR_LO: rd = addr_r[7:0];
                REG_COMMAND: rd = {6'b0, cmd_r};
                REG_CONTROL: rd = ctrl_r;
                REG_TIMING:  rd = timing_r;
                default:     rd = 8'h00;
            endcase
        end
        return rd;
    endfunction

    // ---------------------------------------------------------------
    // Sends one access; called and returns at a falling edge
    task automatic send_access(input logic acc, input logic [2:0] sel, input logic [7:0] wd);
        readback_t item;
        while (idle_enable && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {sel, acc};
        s_tdata  <= wd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        item.acc = acc;
        item.sel = sel;
        item.read_data = bus_access_readback(acc, sel, wd);
        readback_q.push_back(item);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] sel, input logic [7:0] v);
        send_access(OP_WRITE, sel, v);
    endtask

    // write_data is don't-care on reads, so it gets random bits
    task automatic reg_read(input logic [2:0] sel);
        send_access(OP_READ, sel, 8'($urandom()));
    endtask

    task automatic set_address(input logic [15:0] a);
        reg_write(REG_ADDR_HI, a[15:8]);
        reg_write(REG_ADDR_LO, a[7:0]);
    endtask

    task automatic fire_command(input logic [1:0] op);
        reg_write(REG_COMMAND, {6'b0, op});
        reg_write(REG_TRIGGER, TRIG_FIRST);
        reg_write(REG_TRIGGER, TRIG_SECOND);
    endtask

    // ---------------------------------------------------------------
    // Register widths, unused selector, trigger read-back
    task automatic test_register_file();
        reg_write(REG_COMMAND, 8'hFF);
        reg_read(REG_COMMAND);
        reg_write(REG_UNUSED, 8'hFF);
        reg_read(REG_UNUSED);
        reg_read(REG_TRIGGER);
        reg_write(REG_TIMING, 8'hFF);
        reg_read(REG_TIMING);
    endtask

    // Disabled fire, arming across other accesses, broken sequences, idle command
    task automatic test_trigger_rules();
        reg_write(REG_CONTROL, 8'h7F);
        set_address(16'(STORE_BYTES - 1));
        reg_write(REG_DATA, 8'h00);
        fire_command(CMD_PROGRAM);
        reg_write(REG_CONTROL, 8'h80);
        reg_write(REG_TRIGGER, TRIG_FIRST);
        reg_read(REG_TIMING);
        reg_write(REG_TRIGGER, TRIG_SECOND);
        reg_write(REG_DATA, 8'h33);
        reg_write(REG_TRIGGER, TRIG_FIRST);
        reg_write(REG_TRIGGER, 8'h00);
        reg_write(REG_TRIGGER, TRIG_SECOND);
        fire_command(CMD_IDLE);
    endtask

    // Read, erase and out-of-range addressing
    task automatic test_store_commands();
        fire_command(CMD_READ);
        reg_read(REG_DATA);
        fire_command(CMD_ERASE);
        fire_command(CMD_READ);
        reg_read(REG_DATA);
        set_address(16'(STORE_BYTES));
        reg_write(REG_DATA, 8'h12);
        fire_command(CMD_PROGRAM);
        fire_command(CMD_READ);
        reg_read(REG_DATA);
    endtask

    // Output held off while the sender keeps offering accesses
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++) begin
            if (i % 2 == 0) reg_read(3'($urandom_range(0, 7)));
            else reg_write(REG_TIMING, 8'($urandom()));
        end
    endtask

    // One command sequence with random content, sometimes broken
    task automatic run_store_sequence();
        logic [1:0]  op;
        logic [15:0] a;
        logic [7:0]  bad_key;
        int r;
        r = $urandom_range(0, 99);
        op = (r < 40) ? CMD_PROGRAM : (r < 80) ? CMD_READ : (r < 88) ? CMD_ERASE : CMD_IDLE;

        // Mostly a few hot spots near page edges, so programs get read back
        r = $urandom_range(0, 99);
        if (r < 80)
            a = 16'($urandom_range(0, STORE_BYTES / PAGE_BYTES - 1) * PAGE_BYTES +
                    (($urandom_range(0, 1) == 0) ? $urandom_range(0, 7)
                                                 : PAGE_BYTES - 1 - $urandom_range(0, 7)));
        else if (r < 92)
            a = 16'($urandom_range(STORE_BYTES, 16'hFFFF));
        else
            a = 16'($urandom());
        set_address(a);

        if (op == CMD_PROGRAM) reg_write(REG_DATA, 8'($urandom()));
        if (!ctrl_r[ENABLE_BIT] || $urandom_range(0, 99) < 10)
            reg_write(REG_CONTROL, {$urandom_range(0, 99) < 90, 7'($urandom())});
        reg_write(REG_COMMAND, {6'($urandom()), op});

        r = $urandom_range(0, 99);
        if (r < 80) begin
            reg_write(REG_TRIGGER, TRIG_FIRST);
            if ($urandom_range(0, 99) < 10) reg_read(3'($urandom_range(0, 7)));
            reg_write(REG_TRIGGER, TRIG_SECOND);
        end else if (r < 90) begin
            bad_key = 8'($urandom());
            if (bad_key == TRIG_SECOND || bad_key == TRIG_FIRST) bad_key = 8'h00;
            reg_write(REG_TRIGGER, TRIG_FIRST);
            reg_write(REG_TRIGGER, bad_key);
        end else begin
            reg_write(REG_TRIGGER, TRIG_SECOND);
        end

        if (op == CMD_READ) reg_read(REG_DATA);
        if ($urandom_range(0, 99) < 20) reg_read(3'($urandom_range(0, 7)));
    endtask

    // Mostly well-formed sequences, the rest raw accesses; one stretch at full rate
    task automatic test_random_traffic();
        int start;
        int done_count;
        start = items_sent;
        done_count = 0;
        while (done_count < RANDOM_ACCESSES) begin
            idle_enable = !(done_count >= 300 && done_count < 450);
            if ($urandom_range(0, 99) < 75) begin
                run_store_sequence();
            end else begin
                repeat ($urandom_range(1, 4))
                    send_access(1'($urandom()), 3'($urandom_range(0, 7)), 8'($urandom()));
            end
            done_count = items_sent - start;
        end
        idle_enable = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Output side: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge aclk);
                hold_request = 1'b0;
            end
            if (!aresetn) m_tready <= 1'b0;
            else if (!idle_enable) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 99) >= 16);
        end
    end

    // Compare each read_data transaction with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (readback_q.size() == 0) begin
                $error("unexpected transaction, read_data actual 0x%02h", m_tdata);
                fail_count++;
            end else begin
                want = readback_q.pop_front();
                if (m_tdata !== want.read_data) begin
                    $error("read_data (acc %0d reg %0d): expected 0x%02h, actual 0x%02h",
                           want.acc, want.sel, want.read_data, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 4'h0;
        fail_count = 0;
        items_sent = 0;
        n_store_reads = 0;
        n_programs = 0;
        n_erases = 0;
        n_ignored = 0;
        idle_enable = 1'b1;
        hold_request = 1'b0;
        foreach (flash_img[i]) flash_img[i] = ERASED_BYTE;
        data_r = 8'h00;
        addr_r = 16'h0000;
        cmd_r = CMD_IDLE;
        ctrl_r = 8'h00;
        timing_r = 8'h00;
        armed_r = 1'b0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_register_file();
        test_trigger_rules();
        test_store_commands();
        test_backpressure();
        test_random_traffic();
        s_tvalid <= 1'b0;

        // Drain, then leave room for a page erase still in progress
        wait (readback_q.size() == 0);
        repeat (PAGE_BYTES + 16) @(posedge aclk);

        $display("Covered %0d register accesses, with random stalls, a full-rate stretch",
                 items_sent);
        $display("and a %0d-cycle output hold-off; fired %0d reads, %0d programs, %0d erases, %0d ignored.",
                 HOLD_CYCLES, n_store_reads, n_programs, n_erases, n_ignored);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
